// ===== src/kcore_peeling_engine_macros.svh =====
// Assertion macros shared by the k-core peeling engine RTL.
`ifndef KCORE_PEELING_ENGINE_MACROS_SVH
`define KCORE_PEELING_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/kcp_pkg.sv =====
// Types and constants shared by the k-core peeling engine modules.
package kcp_pkg;

   localparam int KIND_W  = 2;
   localparam int INDEX_W = 13;
   localparam int VALUE_W = 14;
   localparam int CNT_W   = 11;
   localparam int LVL_W   = 15;

   localparam logic [KIND_W-1:0] KIND_LOAD_OFFSET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_NEIGHBOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN           = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ          = 2'd3;

   localparam logic [LVL_W-1:0] LEVEL_LIMIT = 15'd16384;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } kcp_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] result_value;
      logic               error;
   } kcp_rsp_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [VALUE_W-1:0] kmax;
   } kcp_run_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INIT_WT,
      ST_SCAN_RD,
      ST_SCAN_WT,
      ST_DQ_CHK,
      ST_DQ_WT,
      ST_OFF_LO,
      ST_OFF_HI,
      ST_NB_CHK,
      ST_NB_WT,
      ST_DEG_WT,
      ST_LVL_END,
      ST_DONE
   } kcp_state_type;

endpackage

// ===== src/kcp_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module kcp_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 14,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/kcp_engine.sv =====
// Peeling sequencer: computes degrees, then peels level by level over the memories.
module kcp_engine #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192,
   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int OW = $clog2(MAX_VERTICES + 1),
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        run_start,
   input  logic [kcp_pkg::CNT_W-1:0]   nv,
   output logic [OW-1:0]               off_raddr,
   input  logic [kcp_pkg::VALUE_W-1:0] off_rdata,
   output logic [EW-1:0]               nbr_raddr,
   input  logic [kcp_pkg::VALUE_W-1:0] nbr_rdata,
   output logic [VW-1:0]               deg_raddr,
   input  logic [kcp_pkg::VALUE_W-1:0] deg_rdata,
   output logic                        deg_we,
   output logic [VW-1:0]               deg_waddr,
   output logic [kcp_pkg::VALUE_W-1:0] deg_wdata,
   output kcp_pkg::kcp_run_stat_type   stat
);
   import kcp_pkg::*;

   localparam int TW = $clog2(MAX_VERTICES + 1);

   kcp_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   vtx_ff;
   logic [VALUE_W-1:0] prev_ff;
   logic [LVL_W-1:0]   level_ff;
   logic [TW-1:0]      head_ff, tail_ff, removed_ff;
   logic [VW-1:0]      vert_ff;
   logic [VALUE_W-1:0] j_ff, hi_ff, u_ff, kmax_ff;

   logic [VW-1:0]      que_raddr, que_rdata, push_vtx;
   logic               push_en, push_ok;
   logic [TW:0]        removed_sum;
   logic [LVL_W-1:0]   level_nxt;
   logic               more_levels, nb_more, u_ok, deg_hit, deg_above;
   logic [VALUE_W-1:0] deg_dec, init_deg;

   kcp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_que (
      .clock (clock),
      .we    (push_en && push_ok),
      .waddr (VW'(tail_ff)),
      .wdata (push_vtx),
      .raddr (que_raddr),
      .rdata (que_rdata)
   );

   assign removed_sum = {1'b0, removed_ff} + {1'b0, tail_ff};
   assign level_nxt   = level_ff + LVL_W'(1);
   assign more_levels = (32'(removed_sum) < 32'(nv)) && (level_nxt < LEVEL_LIMIT);
   assign nb_more     = (j_ff < hi_ff) && (32'(j_ff) < 32'(MAX_EDGES));
   assign u_ok        = 32'(nbr_rdata) < 32'(nv);
   assign deg_hit     = {1'b0, deg_rdata} == level_ff;
   assign deg_above   = {1'b0, deg_rdata} > level_ff;
   assign deg_dec     = deg_rdata - VALUE_W'(1);
   assign init_deg    = (off_rdata >= prev_ff) ? (off_rdata - prev_ff) : '0;
   assign push_ok     = 32'(tail_ff) < 32'(MAX_VERTICES);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (run_start) state_in = (nv == '0) ? ST_DONE : ST_INIT_RD;
         ST_INIT_RD: state_in = ST_INIT_WT;
         ST_INIT_WT: state_in = (vtx_ff == nv) ? ST_SCAN_RD : ST_INIT_RD;
         ST_SCAN_RD: state_in = ST_SCAN_WT;
         ST_SCAN_WT: state_in = (vtx_ff + CNT_W'(1) == nv) ? ST_DQ_CHK : ST_SCAN_RD;
         ST_DQ_CHK:  state_in = (head_ff < tail_ff) ? ST_DQ_WT : ST_LVL_END;
         ST_DQ_WT:   state_in = ST_OFF_LO;
         ST_OFF_LO:  state_in = ST_OFF_HI;
         ST_OFF_HI:  state_in = ST_NB_CHK;
         ST_NB_CHK:  state_in = nb_more ? ST_NB_WT : ST_DQ_CHK;
         ST_NB_WT:   state_in = u_ok ? ST_DEG_WT : ST_NB_CHK;
         ST_DEG_WT:  state_in = ST_NB_CHK;
         ST_LVL_END: state_in = more_levels ? ST_SCAN_RD : ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      off_raddr = OW'(vtx_ff);
      nbr_raddr = EW'(j_ff);
      deg_raddr = VW'(vtx_ff);
      que_raddr = VW'(head_ff);
      deg_we    = 1'b0;
      deg_waddr = VW'(u_ff);
      deg_wdata = deg_dec;
      push_en   = 1'b0;
      push_vtx  = VW'(vtx_ff);
      unique case (state_ff)
         ST_INIT_WT: begin
            deg_we    = vtx_ff != '0;
            deg_waddr = VW'(vtx_ff - CNT_W'(1));
            deg_wdata = init_deg;
         end
         ST_SCAN_WT: push_en = deg_hit;
         ST_DQ_WT:   off_raddr = OW'(que_rdata);
         ST_OFF_LO:  off_raddr = OW'(vert_ff) + OW'(1);
         ST_NB_WT:   deg_raddr = VW'(nbr_rdata);
         ST_DEG_WT: begin
            deg_we   = deg_above;
            push_en  = deg_above && ({1'b0, deg_dec} == level_ff);
            push_vtx = VW'(u_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         vtx_ff     <= '0;
         level_ff   <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         removed_ff <= '0;
         kmax_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (push_en && push_ok) begin
            tail_ff <= tail_ff + TW'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               vtx_ff     <= '0;
               level_ff   <= '0;
               head_ff    <= '0;
               tail_ff    <= '0;
               removed_ff <= '0;
               kmax_ff    <= '0;
            end
            ST_INIT_WT: begin
               prev_ff <= off_rdata;
               vtx_ff  <= (vtx_ff == nv) ? '0 : vtx_ff + CNT_W'(1);
            end
            ST_SCAN_WT: vtx_ff <= (vtx_ff + CNT_W'(1) == nv) ? '0 : vtx_ff + CNT_W'(1);
            ST_DQ_WT:   vert_ff <= que_rdata;
            ST_OFF_LO:  j_ff <= off_rdata;
            ST_OFF_HI:  hi_ff <= off_rdata;
            ST_NB_CHK:  if (!nb_more) head_ff <= head_ff + TW'(1);
            ST_NB_WT: begin
               u_ff <= nbr_rdata;
               if (!u_ok) j_ff <= j_ff + VALUE_W'(1);
            end
            ST_DEG_WT:  j_ff <= j_ff + VALUE_W'(1);
            ST_LVL_END: begin
               removed_ff <= TW'(removed_sum);
               level_ff   <= level_nxt;
               kmax_ff    <= VALUE_W'(level_ff);
               head_ff    <= '0;
               tail_ff    <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.busy = state_ff != ST_IDLE;
   assign stat.done = state_ff == ST_DONE;
   assign stat.kmax = kmax_ff;

endmodule

// ===== src/kcore_peeling_engine.sv =====
// Top level of the k-core peeling engine: command decode, memories and response.
//
// Usage: a command transaction is accepted at a rising edge with start high and
// busy low; req_data carries kind, index and value. Every command returns one
// transaction on rsp_data, marked by rsp_strobe for a single cycle; the receiver
// cannot stall it.
// Load offset, load neighbor and read core number answer in the cycle after
// acceptance and never raise busy, so they can be issued every cycle.
// A run raises busy for its whole duration. The sequencer first derives each
// vertex degree from the offsets, then for each level scans every vertex, walks
// the neighbor slots of each queued vertex and closes the level; kmax is
// returned after the last level ends.
// The vertex count register is written through csr_we and csr_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset clears the control state and sets the vertex count to one; the graph and
// degree memories keep no reset value and must be loaded before a run.
module kcore_peeling_engine #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  kcp_pkg::kcp_req_type      req_data,
   output logic                      rsp_strobe,
   output kcp_pkg::kcp_rsp_type      rsp_data,
   input  logic                      csr_we,
   input  logic [kcp_pkg::CNT_W-1:0] csr_wdata
);
   import kcp_pkg::*;
`include "kcore_peeling_engine_macros.svh"

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int OW = $clog2(MAX_VERTICES + 1);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   logic [CNT_W-1:0]   count_ff, nv;
   logic               busy_ff, busy_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               read_pend_ff, read_pend_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_error_ff, rsp_error_in;
   logic               accept, off_ok, nbr_ok, read_ok;

   logic [OW-1:0]      eng_off_raddr;
   logic [EW-1:0]      eng_nbr_raddr;
   logic [VW-1:0]      eng_deg_raddr, deg_raddr, deg_waddr;
   logic [VALUE_W-1:0] off_rdata, nbr_rdata, deg_rdata, deg_wdata;
   logic               deg_we;
   kcp_run_stat_type   run_stat;

   assign nv = (32'(count_ff) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_ff;

   assign accept  = start && !busy_ff;
   assign off_ok  = 32'(req_data.index) <= 32'(MAX_VERTICES);
   assign nbr_ok  = 32'(req_data.index) < 32'(MAX_EDGES);
   assign read_ok = 32'(req_data.index) < 32'(nv);

   kcp_ram #(.DEPTH(MAX_VERTICES + 1), .WIDTH(VALUE_W)) u_off (
      .clock (clock),
      .we    (accept && (req_data.kind == KIND_LOAD_OFFSET) && off_ok),
      .waddr (OW'(req_data.index)),
      .wdata (req_data.value),
      .raddr (eng_off_raddr),
      .rdata (off_rdata)
   );

   kcp_ram #(.DEPTH(MAX_EDGES), .WIDTH(VALUE_W)) u_nbr (
      .clock (clock),
      .we    (accept && (req_data.kind == KIND_LOAD_NEIGHBOR) && nbr_ok),
      .waddr (EW'(req_data.index)),
      .wdata (req_data.value),
      .raddr (eng_nbr_raddr),
      .rdata (nbr_rdata)
   );

   // The engine owns the degree read port during a run; otherwise core reads use it.
   assign deg_raddr = busy_ff ? eng_deg_raddr : VW'(req_data.index);

   kcp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VALUE_W)) u_deg (
      .clock (clock),
      .we    (deg_we),
      .waddr (deg_waddr),
      .wdata (deg_wdata),
      .raddr (deg_raddr),
      .rdata (deg_rdata)
   );

   kcp_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .run_start (accept && (req_data.kind == KIND_RUN)),
      .nv        (nv),
      .off_raddr (eng_off_raddr),
      .off_rdata (off_rdata),
      .nbr_raddr (eng_nbr_raddr),
      .nbr_rdata (nbr_rdata),
      .deg_raddr (eng_deg_raddr),
      .deg_rdata (deg_rdata),
      .deg_we    (deg_we),
      .deg_waddr (deg_waddr),
      .deg_wdata (deg_wdata),
      .stat      (run_stat)
   );

   always_comb begin
      busy_in       = busy_ff;
      rsp_strobe_in = 1'b0;
      read_pend_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_error_in  = 1'b0;
      if (run_stat.done) begin
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b1;
         rsp_value_in  = run_stat.kmax;
      end else if (accept) begin
         unique case (req_data.kind)
            KIND_LOAD_OFFSET: begin
               rsp_strobe_in = 1'b1;
               rsp_error_in  = !off_ok;
            end
            KIND_LOAD_NEIGHBOR: begin
               rsp_strobe_in = 1'b1;
               rsp_error_in  = !nbr_ok;
            end
            KIND_RUN: busy_in = 1'b1;
            KIND_READ: begin
               rsp_strobe_in = 1'b1;
               rsp_error_in  = !read_ok;
               read_pend_in  = read_ok;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CNT_W'(1);
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         read_pend_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         read_pend_ff  <= read_pend_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign busy                  = busy_ff;
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_data.result_value = read_pend_ff ? deg_rdata : rsp_value_ff;
   assign rsp_data.error        = rsp_error_ff;

   `KCP_ASSERT_NEXT(a_run_sets_busy, clock, reset, accept && (req_data.kind == KIND_RUN), busy, "run did not raise busy")
   `KCP_ASSERT_NEXT(a_run_no_early_rsp, clock, reset, accept && (req_data.kind == KIND_RUN), !rsp_strobe, "run answered too early")
   `KCP_ASSERT_NEXT(a_short_cmd_rsp, clock, reset, accept && (req_data.kind != KIND_RUN), rsp_strobe, "command lost its response")
   `KCP_ASSERT_SAME(a_engine_in_run, clock, reset, run_stat.busy, busy_ff, "engine active outside a run")
   `KCP_ASSERT_SAME(a_read_no_error, clock, reset, read_pend_ff, rsp_strobe && !rsp_data.error, "core read response malformed")

endmodule

// ===== bench/kcore_peeling_engine_test.sv =====
// Self-checking testbench for the k-core peeling engine: directed table, then random graphs.
`timescale 1ns / 100ps

module kcore_peeling_engine_test;
   import kcp_pkg::*;

   localparam int NV_MAX      = 1024;
   localparam int NE_MAX      = 8192;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      kcp_req_type req;
      bit          known;
      kcp_rsp_type rsp;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   kcp_req_type       req_data = '0;
   logic              rsp_strobe;
   kcp_rsp_type       rsp_data;
   logic              csr_we = 1'b0;
   logic [CNT_W-1:0]  csr_wdata = '0;

   // Shadow copy of the engine state used to predict every transaction.
   int unsigned       shadow_offset [0:NV_MAX];
   int unsigned       shadow_neighbor [0:NE_MAX-1];
   int unsigned       shadow_degree [0:NV_MAX-1];
   int unsigned       shadow_queue [0:NV_MAX-1];
   logic [CNT_W-1:0]  shadow_count = 1;
   // Degree entries below this vertex have been written by some earlier run.
   int unsigned       deg_written = 0;

   kcp_rsp_type       pending_rsp [$];
   stim_row_type      directed_rows [$];
   int                fail_count = 0;
   int                cycle_count = 0;
   int                idle_pct = 0;
   int                item_count = 0;
   int                run_count = 0;
   int                graph_count = 0;

   kcore_peeling_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d transactions still expected", $time, pending_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int unsigned peel_graph();
      int unsigned nv, level, removed, head, tail, lo, hi, u, v, j;
      nv = (shadow_count > NV_MAX) ? NV_MAX : shadow_count;
      if (nv == 0) return 0;
      for (v = 0; v < nv; v++) begin
         lo = shadow_offset[v];
         hi = shadow_offset[v+1];
         shadow_degree[v] = (hi >= lo) ? hi - lo : 0;
      end
      level = 0;
      removed = 0;
      while (removed < nv && level < LEVEL_LIMIT) begin
         tail = 0;
         for (v = 0; v < nv; v++)
            if (shadow_degree[v] == level && tail < NV_MAX) begin
               shadow_queue[tail] = v;
               tail++;
            end
         head = 0;
         while (head < tail) begin
            v = shadow_queue[head];
            lo = shadow_offset[v];
            hi = shadow_offset[v+1];
            for (j = lo; j < hi && j < NE_MAX; j++) begin
               u = shadow_neighbor[j];
               if (u < nv && shadow_degree[u] > level) begin
                  shadow_degree[u]--;
                  if (shadow_degree[u] == level && tail < NV_MAX) begin
                     shadow_queue[tail] = u;
                     tail++;
                  end
               end
            end
            head++;
         end
         removed += tail;
         level++;
      end
      return (level - 1) & 16'h3FFF;
   endfunction

   function automatic kcp_rsp_type predict_core(kcp_req_type r);
      kcp_rsp_type res;
      int unsigned nv;
      res = '0;
      nv = (shadow_count > NV_MAX) ? NV_MAX : shadow_count;
      case (r.kind)
         KIND_LOAD_OFFSET: begin
            if (r.index <= NV_MAX) shadow_offset[r.index] = r.value;
            else res.error = 1'b1;
         end
         KIND_LOAD_NEIGHBOR: begin
            if (r.index < NE_MAX) shadow_neighbor[r.index] = r.value;
            else res.error = 1'b1;
         end
         KIND_RUN: res.result_value = VALUE_W'(peel_graph());
         default: begin
            if (r.index < nv) res.result_value = VALUE_W'(shadow_degree[r.index]);
            else res.error = 1'b1;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      kcp_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, actual %0d/%0b", $time,
                     rsp_data.result_value, rsp_data.error);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               $display("%0t: result_value mismatch, expected %0d actual %0d", $time,
                        want.result_value, rsp_data.result_value);
               fail_count++;
            end
            if (rsp_data.error !== want.error) begin
               $display("%0t: error mismatch, expected %0b actual %0b", $time,
                        want.error, rsp_data.error);
               fail_count++;
            end
         end
      end
   end

   // Holds start until the engine takes the transaction, then maybe idles.
   task automatic send_cmd(kcp_req_type r, bit known = 0, kcp_rsp_type fixed = '0);
      kcp_rsp_type want;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      want = predict_core(r);
      pending_rsp.push_back(known ? fixed : want);
      item_count++;
      if (r.kind == KIND_RUN) run_count++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic issue(logic [KIND_W-1:0] k, int unsigned idx, int unsigned val);
      kcp_req_type r;
      r.kind = k;
      r.index = INDEX_W'(idx);
      r.value = VALUE_W'(val);
      send_cmd(r);
   endtask

   task automatic drain_and_set_count(int unsigned cnt);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= CNT_W'(cnt);
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_count = CNT_W'(cnt);
   endtask

   function automatic void add_row(logic [KIND_W-1:0] k, int unsigned idx, int unsigned val,
                                   bit known, int unsigned res, bit err);
      stim_row_type row;
      row.req.kind = k;
      row.req.index = INDEX_W'(idx);
      row.req.value = VALUE_W'(val);
      row.known = known;
      row.rsp.result_value = VALUE_W'(res);
      row.rsp.error = err;
      directed_rows.push_back(row);
   endfunction

   // Loads a random graph for the current vertex count, peels it and reads it back.
   task automatic random_graph();
      int unsigned nv, slots, d, i, maxd;
      nv = (shadow_count > NV_MAX) ? NV_MAX : shadow_count;
      maxd = (nv > 64) ? 3 : 6;
      slots = 0;
      issue(KIND_LOAD_OFFSET, 0, 0);
      for (i = 1; i <= nv; i++) begin
         if ($urandom_range(9) == 0 && shadow_offset[i-1] > 0)
            d = shadow_offset[i-1] - $urandom_range(shadow_offset[i-1], 1);
         else
            d = shadow_offset[i-1] + $urandom_range(maxd);
         issue(KIND_LOAD_OFFSET, i, d);
         if (d > slots) slots = d;
         if ($urandom_range(15) == 0)
            issue(KIND_LOAD_OFFSET, $urandom_range(8191, NV_MAX + 1), $urandom_range(16383));
      end
      for (i = 0; i < slots; i++) begin
         case ($urandom_range(9))
            0:       d = $urandom_range(16383);
            1:       d = nv + $urandom_range(2);
            default: d = (nv > 0) ? $urandom_range(nv - 1) : 0;
         endcase
         issue(KIND_LOAD_NEIGHBOR, i, d);
         if ($urandom_range(19) == 0)
            issue(KIND_LOAD_NEIGHBOR, $urandom_range(8191, 4096), $urandom_range(16383));
      end
      issue(KIND_RUN, $urandom_range(8191), $urandom_range(16383));
      if (nv > deg_written) deg_written = nv;
      if (nv <= 64) begin
         for (i = 0; i < nv; i++) issue(KIND_READ, i, $urandom_range(16383));
      end else begin
         repeat (40) issue(KIND_READ, $urandom_range(nv - 1), $urandom_range(16383));
      end
      repeat (2) issue(KIND_READ, $urandom_range(8191, nv), $urandom_range(16383));
      graph_count++;
   endtask

   initial begin
      int unsigned cnt, target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: field extremes, range errors, and a vertex whose list runs
      // past the end of the neighbor store.
      add_row(KIND_LOAD_OFFSET,   0,    0,     1, 0, 0);
      add_row(KIND_LOAD_OFFSET,   1024, 16383, 1, 0, 0);
      add_row(KIND_LOAD_OFFSET,   1025, 16383, 1, 0, 1);
      add_row(KIND_LOAD_OFFSET,   8191, 5,     1, 0, 1);
      add_row(KIND_LOAD_NEIGHBOR, 0,    16383, 1, 0, 0);
      add_row(KIND_LOAD_NEIGHBOR, 8191, 16383, 1, 0, 0);
      add_row(KIND_LOAD_OFFSET,   0,    8190,  1, 0, 0);
      add_row(KIND_LOAD_OFFSET,   1,    8194,  1, 0, 0);
      add_row(KIND_LOAD_NEIGHBOR, 8190, 0,     1, 0, 0);
      add_row(KIND_LOAD_NEIGHBOR, 8191, 0,     1, 0, 0);
      add_row(KIND_RUN,           8191, 16383, 0, 0, 0);
      add_row(KIND_READ,          0,    0,     0, 0, 0);
      add_row(KIND_READ,          1,    0,     1, 0, 1);
      add_row(KIND_READ,          8191, 16383, 1, 0, 1);
      add_row(KIND_LOAD_OFFSET,   1,    8189,  1, 0, 0);
      add_row(KIND_RUN,           0,    0,     0, 0, 0);
      add_row(KIND_READ,          0,    0,     1, 0, 0);
      foreach (directed_rows[i])
         send_cmd(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp);
      deg_written = 1;

      // No vertices: the run answers zero and every read is out of range.
      drain_and_set_count(0);
      send_cmd('{kind: KIND_RUN, index: 0, value: 0}, 1, '0);
      send_cmd('{kind: KIND_READ, index: 0, value: 0}, 1, '{result_value: 0, error: 1});

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 16 : (phase == 1) ? 66 : 0;
         target = item_count + 400;
         while (item_count < target) begin
            case ($urandom_range(11))
               0:       cnt = 2047;
               1:       cnt = 1024;
               2:       cnt = 0;
               3:       cnt = 1;
               default: cnt = $urandom_range(24, 2);
            endcase
            if (phase == 1 && $urandom_range(6) == 0) cnt = 1025;
            drain_and_set_count(cnt);
            if (cnt > NV_MAX / 2) begin
               // Large counts saturate; only degrees left by earlier runs are read back.
               repeat (3) issue(KIND_READ, $urandom_range(deg_written - 1),
                                $urandom_range(16383));
               repeat (2) issue(KIND_READ, $urandom_range(8191, NV_MAX), $urandom_range(16383));
            end else begin
               random_graph();
            end
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d transactions: %0d peeling runs over %0d random graphs,", item_count,
               run_count, graph_count);
      $display("with range errors, empty and saturated vertex counts, and three idle profiles.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
